>>> sv/complex_sample_arithmetic_unit_macros.svh
// Assertion macros for the complex sample arithmetic unit.
`ifndef COMPLEX_SAMPLE_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_SAMPLE_ARITHMETIC_UNIT_MACROS_SVH
`ifndef SYNTH
`define CSAU_ASSERT(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("csau assertion failed");
`define CSAU_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("csau assertion failed");
`else
`define CSAU_ASSERT(label, cond)
`define CSAU_ASSERT_IMPLY(label, ante, cons)
`endif
`endif

>>> sv/csau_pkg.sv
// Types, constants and helpers of the complex sample arithmetic unit.
`timescale 1ns / 1ps
package csau_pkg;

   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int PROD_W = 2 * DATA_W;
   localparam int WIDE_W = 2 * DATA_W + 2;
   localparam int DEN_W  = 2 * DATA_W;
   localparam int NUM_W  = 2 * DATA_W + 1;
   localparam int DIVD_W = NUM_W + FRAC_W;
   localparam int QUO_W  = DATA_W + 1;
   localparam int TOP_W  = DIVD_W - QUO_W;

   localparam logic [3:0] FUNC_COPY = 4'd0;
   localparam logic [3:0] FUNC_ADD  = 4'd1;
   localparam logic [3:0] FUNC_SUB  = 4'd2;
   localparam logic [3:0] FUNC_MUL  = 4'd3;
   localparam logic [3:0] FUNC_DIV  = 4'd4;
   localparam logic [3:0] FUNC_MIN  = 4'd5;
   localparam logic [3:0] FUNC_MAX  = 4'd6;
   localparam logic [3:0] FUNC_SQR  = 4'd7;
   localparam logic [3:0] FUNC_INV  = 4'd8;
   localparam logic [3:0] FUNC_CONJ = 4'd9;
   localparam logic [3:0] FUNC_ABS  = 4'd10;
   localparam logic [3:0] FUNC_SIGN = 4'd11;
   localparam logic [3:0] FUNC_SSQR = 4'd12;

   localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [QUO_W-1:0] QLIM_POS = {2'b00, {(DATA_W-1){1'b1}}};
   localparam logic [QUO_W-1:0] QLIM_NEG = {2'b01, {(DATA_W-1){1'b0}}};
   localparam logic signed [WIDE_W-1:0] ONE_W = WIDE_W'(1) <<< FRAC_W;

   typedef struct packed {
      logic [3:0]               func;
      logic signed [DATA_W-1:0] a_re;
      logic signed [DATA_W-1:0] a_im;
      logic signed [DATA_W-1:0] b_re;
      logic signed [DATA_W-1:0] b_im;
      logic                     last_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] res_re;
      logic signed [DATA_W-1:0] res_im;
      logic                     last_out;
      logic                     div_by_zero;
      logic                     saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     flag;
   } sat_type;

   // control and non-divide results that ride along the divider stages
   typedef struct packed {
      logic                     last;
      logic                     is_div;
      logic                     dz;
      logic                     neg_re;
      logic                     neg_im;
      logic                     ovf_re;
      logic                     ovf_im;
      logic signed [DATA_W-1:0] res_re;
      logic signed [DATA_W-1:0] res_im;
      logic                     sat;
   } ctl_type;

   function automatic sat_type sat_wide(input logic signed [WIDE_W-1:0] v);
      sat_type r;
      if (v > WIDE_W'(MAX_VAL)) begin
         r.value = MAX_VAL;
         r.flag  = 1'b1;
      end else if (v < WIDE_W'(MIN_VAL)) begin
         r.value = MIN_VAL;
         r.flag  = 1'b1;
      end else begin
         r.value = v[DATA_W-1:0];
         r.flag  = 1'b0;
      end
      return r;
   endfunction

   // signed quotient magnitude to a clipped result
   function automatic sat_type sat_quo(input logic [QUO_W-1:0] q, input logic neg,
                                       input logic ovf);
      sat_type r;
      logic [QUO_W-1:0] nq;
      nq = -q;
      if (neg) begin
         if (ovf || q > QLIM_NEG) begin
            r.value = MIN_VAL;
            r.flag  = 1'b1;
         end else begin
            r.value = nq[DATA_W-1:0];
            r.flag  = 1'b0;
         end
      end else begin
         if (ovf || q > QLIM_POS) begin
            r.value = MAX_VAL;
            r.flag  = 1'b1;
         end else begin
            r.value = q[DATA_W-1:0];
            r.flag  = 1'b0;
         end
      end
      return r;
   endfunction

endpackage

>>> sv/complex_sample_arithmetic_unit.sv
// Top level: pipelined complex arithmetic on signed fixed-point samples.
`timescale 1ns / 1ps
`include "complex_sample_arithmetic_unit_macros.svh"
// Usage:
//   A transaction is taken on every rising edge with start high and busy low.
//   busy stays low: one transaction may enter every clock cycle, with no
//   dependence between them. req_data carries the opcode, both complex
//   operands and the end-of-vector mark.
//   Each transaction yields one result on rsp_data, valid for exactly one
//   cycle while rsp_strobe is high. The receiver cannot stall the block, so
//   there is no back-pressure path; results leave in order.
//   The strobe rises once the transaction has passed the input register,
//   the multiplier stage, the sum stage, the divider setup stage, the
//   restoring divider with one quotient bit per stage over DATA_W + 1
//   stages, and the output register. All opcodes take the same path
//   length so results never reorder.
//   Throughput: one transaction per cycle.
//   Reset (synchronous) clears every stage valid bit; transactions in flight
//   are dropped and no strobe is raised for them.
module complex_sample_arithmetic_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  csau_pkg::req_type req_data,
   output logic              rsp_strobe,
   output csau_pkg::rsp_type rsp_data
);
   import csau_pkg::*;

   localparam int LATENCY = QUO_W + 5;

   // stage 0: input register
   logic    s0_valid_ff, s0_valid_in;
   req_type s0_req_ff;

   // stage 1: products
   logic                     s1_valid_ff;
   req_type                  s1_req_ff;
   logic signed [PROD_W-1:0] s1_m_ff [6];
   logic signed [PROD_W-1:0] s1_m_in [6];
   logic signed [DATA_W-1:0] op_a [6];
   logic signed [DATA_W-1:0] op_b [6];
   logic                     use_aa, use_sqr;

   // stage 2: sums
   logic                     s2_valid_ff;
   logic                     s2_last_ff, s2_div_ff, s2_div_in;
   logic signed [WIDE_W-1:0] s2_rr_ff, s2_ri_ff, s2_rr_in, s2_ri_in;
   logic signed [WIDE_W-1:0] s2_nre_ff, s2_nim_ff, s2_nre_in, s2_nim_in;
   logic [DEN_W-1:0]         s2_den_ff, s2_den_in;
   logic signed [DATA_W-1:0] ar, ai, br, bi;
   logic signed [WIDE_W-1:0] m0w, m1w, m2w, m3w, t_re, t_im, t_sq;

   // stage 3 and divider steps
   logic [QUO_W:0]   dv_valid_ff, dv_valid_in;
   ctl_type          dv_ctl_ff [QUO_W+1];
   ctl_type          dv_ctl_in [QUO_W+1];
   logic [DEN_W-1:0] den_ff [QUO_W+1];
   logic [DEN_W-1:0] den_in [QUO_W+1];
   logic [DEN_W-1:0] rem_re_ff [QUO_W+1];
   logic [DEN_W-1:0] rem_re_in [QUO_W+1];
   logic [DEN_W-1:0] rem_im_ff [QUO_W+1];
   logic [DEN_W-1:0] rem_im_in [QUO_W+1];
   logic [QUO_W-1:0] lo_re_ff [QUO_W+1];
   logic [QUO_W-1:0] lo_re_in [QUO_W+1];
   logic [QUO_W-1:0] lo_im_ff [QUO_W+1];
   logic [QUO_W-1:0] lo_im_in [QUO_W+1];
   logic [QUO_W-1:0] q_re_ff [QUO_W+1];
   logic [QUO_W-1:0] q_re_in [QUO_W+1];
   logic [QUO_W-1:0] q_im_ff [QUO_W+1];
   logic [QUO_W-1:0] q_im_in [QUO_W+1];
   sat_type          s3_sat_re, s3_sat_im;
   logic signed [WIDE_W-1:0] mag_re_w, mag_im_w;
   logic [DIVD_W-1:0] dvd_re, dvd_im;
   logic [DEN_W-1:0]  top_re, top_im;
   logic [DEN_W:0]    sh_re, sh_im;
   logic              ge_re, ge_im;

   // output register
   logic    rsp_strobe_ff;
   rsp_type rsp_data_ff, rsp_data_in;
   sat_type out_re, out_im;

   assign busy        = 1'b0;
   assign s0_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
      s0_req_ff <= req_data;
   end

   // multiplier operand selection
   always_comb begin
      use_aa  = (s0_req_ff.func == FUNC_SQR) || (s0_req_ff.func == FUNC_INV) ||
                (s0_req_ff.func == FUNC_SSQR);
      use_sqr = (s0_req_ff.func == FUNC_SQR);
      op_a[0] = s0_req_ff.a_re;
      op_b[0] = use_aa ? s0_req_ff.a_re : s0_req_ff.b_re;
      op_a[1] = s0_req_ff.a_im;
      op_b[1] = use_aa ? s0_req_ff.a_im : s0_req_ff.b_im;
      op_a[2] = s0_req_ff.a_im;
      op_b[2] = use_sqr ? s0_req_ff.a_re : s0_req_ff.b_re;
      op_a[3] = s0_req_ff.a_re;
      op_b[3] = use_sqr ? s0_req_ff.a_im : s0_req_ff.b_im;
      op_a[4] = s0_req_ff.b_re;
      op_b[4] = s0_req_ff.b_re;
      op_a[5] = s0_req_ff.b_im;
      op_b[5] = s0_req_ff.b_im;
      for (int i = 0; i < 6; i++) begin
         s1_m_in[i] = PROD_W'(op_a[i]) * PROD_W'(op_b[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
      s1_req_ff <= s0_req_ff;
      for (int i = 0; i < 6; i++) begin
         s1_m_ff[i] <= s1_m_in[i];
      end
   end

   // sums, simple opcodes, divider numerators and denominator
   always_comb begin
      ar   = s1_req_ff.a_re;
      ai   = s1_req_ff.a_im;
      br   = s1_req_ff.b_re;
      bi   = s1_req_ff.b_im;
      m0w  = WIDE_W'(s1_m_ff[0]);
      m1w  = WIDE_W'(s1_m_ff[1]);
      m2w  = WIDE_W'(s1_m_ff[2]);
      m3w  = WIDE_W'(s1_m_ff[3]);
      t_re = (m0w - m1w) >>> FRAC_W;
      t_im = (m2w + m3w) >>> FRAC_W;
      t_sq = (ar < 0) ? -m0w : m0w;
      s2_rr_in  = WIDE_W'(ar);
      s2_ri_in  = WIDE_W'(ai);
      s2_nre_in = m0w + m1w;
      s2_nim_in = m2w - m3w;
      s2_den_in = DEN_W'(s1_m_ff[4]) + DEN_W'(s1_m_ff[5]);
      s2_div_in = 1'b0;
      case (s1_req_ff.func)
         FUNC_COPY: begin
            s2_rr_in = WIDE_W'(br);
            s2_ri_in = WIDE_W'(bi);
         end
         FUNC_ADD: begin
            s2_rr_in = WIDE_W'(ar) + WIDE_W'(br);
            s2_ri_in = WIDE_W'(ai) + WIDE_W'(bi);
         end
         FUNC_SUB: begin
            s2_rr_in = WIDE_W'(ar) - WIDE_W'(br);
            s2_ri_in = WIDE_W'(ai) - WIDE_W'(bi);
         end
         FUNC_MUL, FUNC_SQR: begin
            s2_rr_in = t_re;
            s2_ri_in = t_im;
         end
         FUNC_DIV: begin
            s2_div_in = 1'b1;
         end
         FUNC_INV: begin
            s2_div_in = 1'b1;
            s2_nre_in = WIDE_W'(ar) <<< FRAC_W;
            s2_nim_in = -(WIDE_W'(ai) <<< FRAC_W);
            s2_den_in = DEN_W'(s1_m_ff[0]) + DEN_W'(s1_m_ff[1]);
         end
         FUNC_MIN: begin
            if (br < ar) begin
               s2_rr_in = WIDE_W'(br);
            end
         end
         FUNC_MAX: begin
            if (ar < br) begin
               s2_rr_in = WIDE_W'(br);
            end
         end
         FUNC_CONJ: begin
            s2_ri_in = -WIDE_W'(ai);
         end
         FUNC_ABS: begin
            if (ar < 0) begin
               s2_rr_in = -WIDE_W'(ar);
            end
         end
         FUNC_SIGN: begin
            if (ar == 0) begin
               s2_rr_in = '0;
            end else if (ar < 0) begin
               s2_rr_in = -ONE_W;
            end else begin
               s2_rr_in = ONE_W;
            end
         end
         FUNC_SSQR: begin
            s2_rr_in = t_sq >>> FRAC_W;
         end
         default: begin
            s2_div_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_last_ff <= s1_req_ff.last_in;
      s2_div_ff  <= s2_div_in;
      s2_rr_ff   <= s2_rr_in;
      s2_ri_ff   <= s2_ri_in;
      s2_nre_ff  <= s2_nre_in;
      s2_nim_ff  <= s2_nim_in;
      s2_den_ff  <= s2_den_in;
   end

   // divider setup, then one quotient bit per stage on each part
   always_comb begin
      s3_sat_re = sat_wide(s2_rr_ff);
      s3_sat_im = sat_wide(s2_ri_ff);
      mag_re_w  = (s2_nre_ff < 0) ? -s2_nre_ff : s2_nre_ff;
      mag_im_w  = (s2_nim_ff < 0) ? -s2_nim_ff : s2_nim_ff;
      dvd_re    = {mag_re_w[NUM_W-1:0], {FRAC_W{1'b0}}};
      dvd_im    = {mag_im_w[NUM_W-1:0], {FRAC_W{1'b0}}};
      top_re    = DEN_W'(dvd_re[DIVD_W-1 -: TOP_W]);
      top_im    = DEN_W'(dvd_im[DIVD_W-1 -: TOP_W]);

      dv_valid_in = {dv_valid_ff[QUO_W-1:0], s2_valid_ff};

      dv_ctl_in[0].last   = s2_last_ff;
      dv_ctl_in[0].is_div = s2_div_ff;
      dv_ctl_in[0].dz     = s2_div_ff && (s2_den_ff == '0);
      dv_ctl_in[0].neg_re = s2_nre_ff < 0;
      dv_ctl_in[0].neg_im = s2_nim_ff < 0;
      dv_ctl_in[0].ovf_re = top_re >= s2_den_ff;
      dv_ctl_in[0].ovf_im = top_im >= s2_den_ff;
      dv_ctl_in[0].res_re = s3_sat_re.value;
      dv_ctl_in[0].res_im = s3_sat_im.value;
      dv_ctl_in[0].sat    = s3_sat_re.flag || s3_sat_im.flag;
      den_in[0]    = s2_den_ff;
      // an overflowing quotient is clipped anyway; keep the remainder bounded
      rem_re_in[0] = (top_re >= s2_den_ff) ? '0 : top_re;
      rem_im_in[0] = (top_im >= s2_den_ff) ? '0 : top_im;
      lo_re_in[0]  = dvd_re[QUO_W-1:0];
      lo_im_in[0]  = dvd_im[QUO_W-1:0];
      q_re_in[0]   = '0;
      q_im_in[0]   = '0;

      for (int k = 1; k <= QUO_W; k++) begin
         sh_re = {rem_re_ff[k-1], lo_re_ff[k-1][QUO_W-1]};
         sh_im = {rem_im_ff[k-1], lo_im_ff[k-1][QUO_W-1]};
         ge_re = sh_re >= {1'b0, den_ff[k-1]};
         ge_im = sh_im >= {1'b0, den_ff[k-1]};
         rem_re_in[k] = ge_re ? DEN_W'(sh_re - {1'b0, den_ff[k-1]}) : sh_re[DEN_W-1:0];
         rem_im_in[k] = ge_im ? DEN_W'(sh_im - {1'b0, den_ff[k-1]}) : sh_im[DEN_W-1:0];
         lo_re_in[k]  = lo_re_ff[k-1] << 1;
         lo_im_in[k]  = lo_im_ff[k-1] << 1;
         q_re_in[k]   = {q_re_ff[k-1][QUO_W-2:0], ge_re};
         q_im_in[k]   = {q_im_ff[k-1][QUO_W-2:0], ge_im};
         den_in[k]    = den_ff[k-1];
         dv_ctl_in[k] = dv_ctl_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff <= '0;
      end else begin
         dv_valid_ff <= dv_valid_in;
      end
      for (int k = 0; k <= QUO_W; k++) begin
         dv_ctl_ff[k] <= dv_ctl_in[k];
         den_ff[k]    <= den_in[k];
         rem_re_ff[k] <= rem_re_in[k];
         rem_im_ff[k] <= rem_im_in[k];
         lo_re_ff[k]  <= lo_re_in[k];
         lo_im_ff[k]  <= lo_im_in[k];
         q_re_ff[k]   <= q_re_in[k];
         q_im_ff[k]   <= q_im_in[k];
      end
   end

   // result select and clip
   always_comb begin
      out_re = sat_quo(q_re_ff[QUO_W], dv_ctl_ff[QUO_W].neg_re, dv_ctl_ff[QUO_W].ovf_re);
      out_im = sat_quo(q_im_ff[QUO_W], dv_ctl_ff[QUO_W].neg_im, dv_ctl_ff[QUO_W].ovf_im);
      rsp_data_in.last_out    = dv_ctl_ff[QUO_W].last;
      rsp_data_in.div_by_zero = dv_ctl_ff[QUO_W].dz;
      if (dv_ctl_ff[QUO_W].dz) begin
         rsp_data_in.res_re    = '0;
         rsp_data_in.res_im    = '0;
         rsp_data_in.saturated = 1'b0;
      end else if (dv_ctl_ff[QUO_W].is_div) begin
         rsp_data_in.res_re    = out_re.value;
         rsp_data_in.res_im    = out_im.value;
         rsp_data_in.saturated = out_re.flag || out_im.flag;
      end else begin
         rsp_data_in.res_re    = dv_ctl_ff[QUO_W].res_re;
         rsp_data_in.res_im    = dv_ctl_ff[QUO_W].res_im;
         rsp_data_in.saturated = dv_ctl_ff[QUO_W].sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dv_valid_ff[QUO_W];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `CSAU_ASSERT_IMPLY(a_strobe_latency, rsp_strobe, $past(start && !busy, LATENCY))
   `CSAU_ASSERT_IMPLY(a_dz_zero, rsp_strobe && rsp_data.div_by_zero, rsp_data.res_re == '0 && rsp_data.res_im == '0 && !rsp_data.saturated)
   `CSAU_ASSERT_IMPLY(a_sat_rail, rsp_strobe && rsp_data.saturated, rsp_data.res_re == MAX_VAL || rsp_data.res_re == MIN_VAL || rsp_data.res_im == MAX_VAL || rsp_data.res_im == MIN_VAL)

endmodule

>>> test/tb_top.sv
// Testbench for the complex sample arithmetic unit: directed and random transactions.
`timescale 1ns / 1ps
module tb_top;
   import csau_pkg::*;

   localparam int LATENCY = DATA_W + 5;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   rsp_type result_q[$];
   int      fail_count = 0;
   bit      idle_on = 1'b1;

   complex_sample_arithmetic_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // exact wide arithmetic, clipped at the end
   function automatic logic signed [DATA_W-1:0] clip(input logic signed [159:0] v,
                                                      inout logic flag);
      if (v > 160'(MAX_VAL)) begin
         flag = 1'b1;
         return MAX_VAL;
      end
      if (v < 160'(MIN_VAL)) begin
         flag = 1'b1;
         return MIN_VAL;
      end
      return v[DATA_W-1:0];
   endfunction

   function automatic rsp_type compute_sample(input req_type r);
      logic signed [159:0] ar, ai, br, bi, rr, ri, den, one;
      logic dz, sat;
      rsp_type o;
      ar = 160'(r.a_re); ai = 160'(r.a_im); br = 160'(r.b_re); bi = 160'(r.b_im);
      rr = ar; ri = ai; dz = 1'b0; sat = 1'b0;
      one = 160'sd1 <<< FRAC_W;
      case (r.func)
         FUNC_COPY: begin rr = br; ri = bi; end
         FUNC_ADD:  begin rr = ar + br; ri = ai + bi; end
         FUNC_SUB:  begin rr = ar - br; ri = ai - bi; end
         FUNC_MUL: begin
            rr = (ar * br - ai * bi) >>> FRAC_W;
            ri = (ai * br + ar * bi) >>> FRAC_W;
         end
         FUNC_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               dz = 1'b1; rr = '0; ri = '0;
            end else begin
               rr = ((ar * br + ai * bi) <<< FRAC_W) / den;
               ri = ((ai * br - ar * bi) <<< FRAC_W) / den;
            end
         end
         FUNC_MIN: if (br < ar) rr = br;
         FUNC_MAX: if (ar < br) rr = br;
         FUNC_SQR: begin
            rr = (ar * ar - ai * ai) >>> FRAC_W;
            ri = ((ar * ai) <<< 1) >>> FRAC_W;
         end
         FUNC_INV: begin
            den = ar * ar + ai * ai;
            if (den == 0) begin
               dz = 1'b1; rr = '0; ri = '0;
            end else begin
               rr = (ar <<< (2 * FRAC_W)) / den;
               ri = ((-ai) <<< (2 * FRAC_W)) / den;
            end
         end
         FUNC_CONJ: ri = -ai;
         FUNC_ABS:  if (ar < 0) rr = -ar;
         FUNC_SIGN: rr = (ar == 0) ? 160'sd0 : (ar < 0 ? -one : one);
         FUNC_SSQR: rr = (ar * (ar < 0 ? -ar : ar)) >>> FRAC_W;
         default: ;   // unused codes pass a through
      endcase
      o.res_re      = clip(rr, sat);
      o.res_im      = clip(ri, sat);
      o.last_out    = r.last_in;
      o.div_by_zero = dz;
      o.saturated   = sat;
      return o;
   endfunction

   always @(posedge clock) begin
      if (!reset && start && !busy)
         result_q.push_back(compute_sample(req_data));
   end

   task automatic report_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (result_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = result_q.pop_front();
            report_field("res_re", want.res_re, rsp_data.res_re);
            report_field("res_im", want.res_im, rsp_data.res_im);
            report_field("last_out", DATA_W'(want.last_out), DATA_W'(rsp_data.last_out));
            report_field("div_by_zero", DATA_W'(want.div_by_zero),
                         DATA_W'(rsp_data.div_by_zero));
            report_field("saturated", DATA_W'(want.saturated), DATA_W'(rsp_data.saturated));
         end
      end
   end

   // called at a rising edge; returns at the accepting edge or, with idle_on, later
   task automatic send_sample(input req_type r);
      bit taken;
      start    <= 1'b1;
      req_data <= r;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (result_q.size() != 0) @(posedge clock);
   endtask

   function automatic req_type make_sample(input logic [3:0] f, input logic [31:0] are,
                                           input logic [31:0] aim, input logic [31:0] bre,
                                           input logic [31:0] bim);
      req_type r;
      r.func = f; r.a_re = are; r.a_im = aim; r.b_re = bre; r.b_im = bim;
      r.last_in = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return $urandom_range(0, 1) ? MAX_VAL : MIN_VAL;
         2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
         3: return $signed($urandom_range(0, 32'h7ffffff)) - 32'sh4000000;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_sample(make_sample(FUNC_COPY, MAX_VAL, MIN_VAL, MIN_VAL, MAX_VAL));
      send_sample(make_sample(FUNC_ADD, MAX_VAL, MIN_VAL, MAX_VAL, MIN_VAL));
      send_sample(make_sample(FUNC_SUB, MIN_VAL, MAX_VAL, MAX_VAL, MIN_VAL));
      send_sample(make_sample(FUNC_MUL, MIN_VAL, MIN_VAL, MIN_VAL, MAX_VAL));
      send_sample(make_sample(FUNC_MUL, 32'hfffe8000, 32'h00010000, 32'h00020000, 32'hffff0001));
      send_sample(make_sample(FUNC_DIV, 32'h00030000, 32'hfffe0000, 0, 0));
      send_sample(make_sample(FUNC_DIV, MAX_VAL, MIN_VAL, 1, 0));
      send_sample(make_sample(FUNC_DIV, 32'h00010000, 32'h00020000, 32'h00008000, 32'hffff8000));
      send_sample(make_sample(FUNC_DIV, MIN_VAL, 0, MIN_VAL, MIN_VAL));
      send_sample(make_sample(FUNC_MIN, MIN_VAL, 5, MAX_VAL, 7));
      send_sample(make_sample(FUNC_MAX, MIN_VAL, 5, MAX_VAL, 7));
      send_sample(make_sample(FUNC_SQR, MIN_VAL, MAX_VAL, 0, 0));
      send_sample(make_sample(FUNC_INV, 0, 0, 3, 3));
      send_sample(make_sample(FUNC_INV, 1, 0, 0, 0));
      send_sample(make_sample(FUNC_INV, MIN_VAL, MAX_VAL, 0, 0));
      send_sample(make_sample(FUNC_CONJ, 3, MIN_VAL, 0, 0));
      send_sample(make_sample(FUNC_ABS, MIN_VAL, 9, 0, 0));
      send_sample(make_sample(FUNC_ABS, 32'hffff0000, MAX_VAL, 0, 0));
      send_sample(make_sample(FUNC_SIGN, 0, 1, 0, 0));
      send_sample(make_sample(FUNC_SIGN, MIN_VAL, 1, 0, 0));
      send_sample(make_sample(FUNC_SIGN, MAX_VAL, 1, 0, 0));
      send_sample(make_sample(FUNC_SSQR, MIN_VAL, 2, 0, 0));
      send_sample(make_sample(FUNC_SSQR, 32'hfffe8000, 2, 0, 0));
      send_sample(make_sample(4'd13, MAX_VAL, MIN_VAL, 1, 1));
      send_sample(make_sample(4'd15, MIN_VAL, MAX_VAL, 1, 1));
   endtask

   task automatic test_random(input int count);
      repeat (count)
         send_sample(make_sample(4'($urandom_range(0, 15)), rand_operand(), rand_operand(),
                                 rand_operand(), rand_operand()));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain_results();
      test_random(400);
      drain_results();
      test_random(250);
      idle_on = 1'b0;
      test_random(150);
      drain_results();
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

>>> complex_sample_arithmetic_unit.f
+incdir+sv
sv/csau_pkg.sv
sv/complex_sample_arithmetic_unit.sv
test/tb_top.sv
